@@ sv/elt_pkg.sv @@
// shared constants and types of the entity location table
package elt_pkg;

	localparam int DEPTH_DEF      = 32;
	localparam int ID_BITS_DEF    = 16;
	localparam int COORD_BITS_DEF = 16;

	localparam logic [2:0] ACT_FIND   = 3'd0;
	localparam logic [2:0] ACT_MOVE   = 3'd1;
	localparam logic [2:0] ACT_REMOVE = 3'd2;
	localparam logic [2:0] ACT_LOCATE = 3'd3;
	localparam logic [2:0] ACT_VIEW   = 3'd4;
	localparam logic [2:0] ACT_CLEAR  = 3'd5;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_OCCUPIED = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_NOTFOUND = 3'd3;
	localparam logic [2:0] ST_NULL     = 3'd4;

	typedef struct packed {
		logic move_upd;
		logic append;
		logic remove;
		logic clear;
	} cell_ctl_t;

endpackage

@@ sv/entity_location_table_unit.sv @@
// entity location table: row of slot cells with request control and output register
//
// channel   dir  tvalid/tready    tdata (low to high)                          tuser    tlast
// s_axis    in   request word     ent, pos_x, pos_y, corner_x, corner_y        action   -
// m_axis    out  result word      found_id, found_x, found_y                   status   last
//
// find, move, remove, locate, clear: the request word is registered, then executed
// against all cells in parallel; view: one word per matching slot, the scan pointer
// walking the cell row up to the last match. codes 6 and 7 give no result.
// reset clears the slot valid bits at once; no clearing pass.
// a stalled result holds the execute or scan step until the output register frees.
module entity_location_table_unit #(
	parameter int DEPTH      = elt_pkg::DEPTH_DEF,
	parameter int ID_BITS    = elt_pkg::ID_BITS_DEF,
	parameter int COORD_BITS = elt_pkg::COORD_BITS_DEF,
	localparam int S_DW = ((ID_BITS + 4 * COORD_BITS + 7) / 8) * 8,
	localparam int M_DW = ((ID_BITS + 2 * COORD_BITS + 7) / 8) * 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_axis_tvalid,
	output logic            s_axis_tready,
	// ent, pos_x, pos_y, corner_x, corner_y
	input  logic [S_DW-1:0] s_axis_tdata,
	// action
	input  logic [2:0]      s_axis_tuser,
	output logic            m_axis_tvalid,
	input  logic            m_axis_tready,
	// found_id, found_x, found_y
	output logic [M_DW-1:0] m_axis_tdata,
	// status
	output logic [2:0]      m_axis_tuser,
	output logic            m_axis_tlast
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int PAD_W = M_DW - ID_BITS - 2 * COORD_BITS;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_VIEW = 2'd2;

	logic [1:0] state_q;

	logic        [2:0]            act_q;
	logic        [ID_BITS-1:0]    rid_q;
	logic signed [COORD_BITS-1:0] px_q, py_q, cx_q, cy_q;

	logic [DEPTH-1:0] mask_q;
	logic [PTR_W-1:0] ptr_q;

	logic                         m_valid_q;
	logic        [ID_BITS-1:0]    m_id_q;
	logic signed [COORD_BITS-1:0] m_x_q, m_y_q;
	logic        [2:0]            m_st_q;
	logic                         m_last_q;

	logic                         cell_used [DEPTH];
	logic        [ID_BITS-1:0]    cell_id   [DEPTH];
	logic signed [COORD_BITS-1:0] cell_x    [DEPTH];
	logic signed [COORD_BITS-1:0] cell_y    [DEPTH];
	logic                         nb_used   [DEPTH];
	logic        [ID_BITS-1:0]    nb_id     [DEPTH];
	logic signed [COORD_BITS-1:0] nb_x      [DEPTH];
	logic signed [COORD_BITS-1:0] nb_y      [DEPTH];
	logic                         pv_used   [DEPTH];
	logic [DEPTH-1:0]             match_id, match_pos, hit;
	logic [DEPTH:0]               kill_c;

	elt_pkg::cell_ctl_t ctl, ctl_go;

	logic s_fire, out_free, emit, go_view, fire;
	logic any_id, any_pos, any_hit, full;
	logic        [ID_BITS-1:0]    pos_id;
	logic signed [COORD_BITS-1:0] e_x, e_y;
	logic        [2:0]            r_st;
	logic        [ID_BITS-1:0]    r_id;
	logic signed [COORD_BITS-1:0] r_x, r_y;
	logic                         r_last;
	logic [DEPTH-1:0]             rest;

	assign s_axis_tready = (state_q == S_IDLE);
	assign s_fire        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;
	assign kill_c[0]     = 1'b0;
	assign full          = cell_used[DEPTH-1];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign pv_used[i] = 1'b1;
		end else begin : g_mid
			assign pv_used[i] = cell_used[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign nb_used[i] = 1'b0;
			assign nb_id[i]   = '0;
			assign nb_x[i]    = '0;
			assign nb_y[i]    = '0;
		end else begin : g_inner
			assign nb_used[i] = cell_used[i+1];
			assign nb_id[i]   = cell_id[i+1];
			assign nb_x[i]    = cell_x[i+1];
			assign nb_y[i]    = cell_y[i+1];
		end

		elt_cell #(
			.ID_BITS   (ID_BITS),
			.COORD_BITS(COORD_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl_go),
			.req_id   (rid_q),
			.req_px   (px_q),
			.req_py   (py_q),
			.req_cx   (cx_q),
			.req_cy   (cy_q),
			.prev_used(pv_used[i]),
			.prev_kill(kill_c[i]),
			.next_used(nb_used[i]),
			.next_id  (nb_id[i]),
			.next_x   (nb_x[i]),
			.next_y   (nb_y[i]),
			.used     (cell_used[i]),
			.id       (cell_id[i]),
			.x        (cell_x[i]),
			.y        (cell_y[i]),
			.match_id (match_id[i]),
			.match_pos(match_pos[i]),
			.hit      (hit[i]),
			.kill     (kill_c[i+1])
		);
	end

	// entries are unique by id and by location, so at most one cell matches
	always_comb begin
		pos_id = '0;
		e_x    = '0;
		e_y    = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (match_pos[i]) begin
				pos_id = pos_id | cell_id[i];
			end
			if (match_id[i]) begin
				e_x = e_x | cell_x[i];
				e_y = e_y | cell_y[i];
			end
		end
	end

	assign any_id  = |match_id;
	assign any_pos = |match_pos;
	assign any_hit = |hit;
	assign rest    = mask_q & ~({{(DEPTH-1){1'b0}}, 1'b1} << ptr_q);

	always_comb begin
		ctl     = '0;
		emit    = 1'b0;
		go_view = 1'b0;
		r_st    = elt_pkg::ST_OK;
		r_id    = '0;
		r_x     = '0;
		r_y     = '0;
		r_last  = 1'b1;
		if (state_q == S_VIEW) begin
			emit   = mask_q[ptr_q];
			r_id   = cell_id[ptr_q];
			r_x    = cell_x[ptr_q];
			r_y    = cell_y[ptr_q];
			r_last = (rest == '0);
		end else begin
			unique case (act_q) inside
				elt_pkg::ACT_FIND: begin
					emit = 1'b1;
					if (any_pos) begin
						r_id = pos_id;
						r_x  = px_q;
						r_y  = py_q;
					end else begin
						r_st = elt_pkg::ST_NOTFOUND;
					end
				end
				elt_pkg::ACT_MOVE: begin
					emit = 1'b1;
					if (rid_q == '0) begin
						r_st = elt_pkg::ST_NULL;
					end else if (any_pos && (pos_id != rid_q)) begin
						r_st = elt_pkg::ST_OCCUPIED;
						r_id = pos_id;
						r_x  = px_q;
						r_y  = py_q;
					end else begin
						r_id = rid_q;
						r_x  = px_q;
						r_y  = py_q;
						if (any_id) begin
							ctl.move_upd = 1'b1;
						end else if (full) begin
							r_st = elt_pkg::ST_FULL;
						end else begin
							ctl.append = 1'b1;
						end
					end
				end
				elt_pkg::ACT_REMOVE, elt_pkg::ACT_LOCATE: begin
					emit = 1'b1;
					if (rid_q == '0) begin
						r_st = elt_pkg::ST_NULL;
					end else if (!any_id) begin
						r_st = elt_pkg::ST_NOTFOUND;
						r_id = rid_q;
					end else begin
						r_id       = rid_q;
						r_x        = e_x;
						r_y        = e_y;
						ctl.remove = (act_q == elt_pkg::ACT_REMOVE);
					end
				end
				elt_pkg::ACT_VIEW: begin
					if (any_hit) begin
						go_view = 1'b1;
					end else begin
						emit = 1'b1;
						r_st = elt_pkg::ST_NOTFOUND;
					end
				end
				elt_pkg::ACT_CLEAR: begin
					emit      = 1'b1;
					ctl.clear = 1'b1;
				end
				default: begin
					emit = 1'b0;
				end
			endcase
		end
	end

	assign fire   = emit && out_free && (state_q != S_IDLE);
	assign ctl_go = (state_q == S_EXEC && fire) ? ctl : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ptr_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_fire) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (go_view) begin
						state_q <= S_VIEW;
						ptr_q   <= '0;
					end else if (!emit || out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_VIEW: begin
					if (!mask_q[ptr_q]) begin
						ptr_q <= ptr_q + 1'b1;
					end else if (out_free) begin
						ptr_q <= ptr_q + 1'b1;
						if (rest == '0) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			act_q <= s_axis_tuser;
			rid_q <= s_axis_tdata[ID_BITS-1:0];
			px_q  <= s_axis_tdata[ID_BITS +: COORD_BITS];
			py_q  <= s_axis_tdata[ID_BITS + COORD_BITS +: COORD_BITS];
			cx_q  <= s_axis_tdata[ID_BITS + 2 * COORD_BITS +: COORD_BITS];
			cy_q  <= s_axis_tdata[ID_BITS + 3 * COORD_BITS +: COORD_BITS];
		end
		if (state_q == S_EXEC && go_view) begin
			mask_q <= hit;
		end else if (state_q == S_VIEW && fire) begin
			mask_q <= rest;
		end
		if (fire) begin
			m_st_q   <= r_st;
			m_id_q   <= r_id;
			m_x_q    <= r_x;
			m_y_q    <= r_y;
			m_last_q <= r_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (fire) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = m_st_q;
	assign m_axis_tlast  = m_last_q;
	if (PAD_W > 0) begin : g_pad
		assign m_axis_tdata = {{PAD_W{1'b0}}, m_y_q, m_x_q, m_id_q};
	end else begin : g_nopad
		assign m_axis_tdata = {m_y_q, m_x_q, m_id_q};
	end

endmodule

@@ sv/elt_cell.sv @@
// one slot of the table: stored entry, compares, and neighbor hand-off
module elt_cell #(
	parameter int ID_BITS    = elt_pkg::ID_BITS_DEF,
	parameter int COORD_BITS = elt_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  elt_pkg::cell_ctl_t           ctl,
	input  logic        [ID_BITS-1:0]    req_id,
	input  logic signed [COORD_BITS-1:0] req_px,
	input  logic signed [COORD_BITS-1:0] req_py,
	input  logic signed [COORD_BITS-1:0] req_cx,
	input  logic signed [COORD_BITS-1:0] req_cy,
	input  logic                         prev_used,
	input  logic                         prev_kill,
	input  logic                         next_used,
	input  logic        [ID_BITS-1:0]    next_id,
	input  logic signed [COORD_BITS-1:0] next_x,
	input  logic signed [COORD_BITS-1:0] next_y,
	output logic                         used,
	output logic        [ID_BITS-1:0]    id,
	output logic signed [COORD_BITS-1:0] x,
	output logic signed [COORD_BITS-1:0] y,
	output logic                         match_id,
	output logic                         match_pos,
	output logic                         hit,
	output logic                         kill
);

	logic                         used_q;
	logic        [ID_BITS-1:0]    id_q;
	logic signed [COORD_BITS-1:0] x_q;
	logic signed [COORD_BITS-1:0] y_q;
	logic                         tail;

	assign match_id  = used_q && (id_q == req_id);
	assign match_pos = used_q && (x_q == req_px) && (y_q == req_py);
	assign hit       = used_q && (x_q >= req_px) && (x_q <= req_cx)
		&& (y_q >= req_py) && (y_q <= req_cy);
	assign kill      = prev_kill || match_id;
	// first free slot
	assign tail      = prev_used && !used_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
		end else if (ctl.clear) begin
			used_q <= 1'b0;
		end else if (ctl.append && tail) begin
			used_q <= 1'b1;
		end else if (ctl.remove && kill) begin
			used_q <= next_used;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.append && tail) begin
			id_q <= req_id;
			x_q  <= req_px;
			y_q  <= req_py;
		end else if (ctl.move_upd && match_id) begin
			x_q <= req_px;
			y_q <= req_py;
		end else if (ctl.remove && kill) begin
			id_q <= next_id;
			x_q  <= next_x;
			y_q  <= next_y;
		end
	end

	assign used = used_q;
	assign id   = id_q;
	assign x    = x_q;
	assign y    = y_q;

endmodule

@@ sv/elt_checker.sv @@
// port checks of the entity location table and their bind
module elt_checker #(
	parameter int ID_BITS    = elt_pkg::ID_BITS_DEF,
	parameter int COORD_BITS = elt_pkg::COORD_BITS_DEF,
	localparam int M_DW = ((ID_BITS + 2 * COORD_BITS + 7) / 8) * 8
) (
	input logic            clk,
	input logic            arst_n,
	input logic            s_axis_tvalid,
	input logic            s_axis_tready,
	input logic            m_axis_tvalid,
	input logic            m_axis_tready,
	input logic [M_DW-1:0] m_axis_tdata,
	input logic [2:0]      m_axis_tuser,
	input logic            m_axis_tlast
);

	// one request at a time
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request taken while another is executing");

	// no new request in the middle of a view listing
	a_view_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
		else $error("request taken during a view listing");

	// only ok words may be followed by more words of the same request
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != elt_pkg::ST_OK) |-> m_axis_tlast)
		else $error("failing status without last");

	// null entity answers carry no id
	a_null_id: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == elt_pkg::ST_NULL)
		|-> (m_axis_tdata[ID_BITS-1:0] == '0))
		else $error("null entity word with nonzero id");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready
		|=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
		&& $stable(m_axis_tlast))
		else $error("stalled result word changed");

endmodule

bind entity_location_table_unit elt_checker #(
	.ID_BITS   (ID_BITS),
	.COORD_BITS(COORD_BITS)
) u_elt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser),
	.m_axis_tlast (m_axis_tlast)
);

@@ dv/entity_location_table_unit_test.sv @@
// testbench of the entity location table unit
module entity_location_table_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = elt_pkg::DEPTH_DEF;
	localparam int NUM_REQUESTS = 430;
	localparam logic [2:0] ACT_SPARE_LO = 3'd6;
	localparam logic [2:0] ACT_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] id;
		logic [15:0] x;
		logic [15:0] y;
		logic        last;
	} result_word_t;

	class location_scoreboard;
		logic [15:0]  tbl_id [DEPTH];
		logic [15:0]  tbl_x [DEPTH];
		logic [15:0]  tbl_y [DEPTH];
		int           tbl_count = 0;
		result_word_t pending_results [$];
		int           mismatches = 0;

		function void push(logic [2:0] status, logic [15:0] id, logic [15:0] x,
			logic [15:0] y, logic last);
			result_word_t r;
			r.status = status;
			r.id = id;
			r.x = x;
			r.y = y;
			r.last = last;
			pending_results.insert(pending_results.size(), r);
		endfunction

		function int slot_of_entity(logic [15:0] id);
			for (int i = 0; i < tbl_count; i++)
				if (tbl_id[i] == id)
					return i;
			return -1;
		endfunction

		function int slot_at(logic [15:0] x, logic [15:0] y);
			for (int i = 0; i < tbl_count; i++)
				if (tbl_x[i] == x && tbl_y[i] == y)
					return i;
			return -1;
		endfunction

		function bit in_rect(int i, logic [15:0] px, logic [15:0] py,
			logic [15:0] cx, logic [15:0] cy);
			return $signed(tbl_x[i]) >= $signed(px) && $signed(tbl_x[i]) <= $signed(cx) &&
				$signed(tbl_y[i]) >= $signed(py) && $signed(tbl_y[i]) <= $signed(cy);
		endfunction

		function void note_request(logic [2:0] action, logic [15:0] id, logic [15:0] px,
			logic [15:0] py, logic [15:0] cx, logic [15:0] cy);
			int e;
			int p;
			int hits;
			int k;
			case (action)
				elt_pkg::ACT_FIND: begin
					p = slot_at(px, py);
					if (p < 0)
						push(elt_pkg::ST_NOTFOUND, 16'd0, 16'd0, 16'd0, 1'b1);
					else
						push(elt_pkg::ST_OK, tbl_id[p], px, py, 1'b1);
				end
				elt_pkg::ACT_MOVE: begin
					e = slot_of_entity(id);
					p = slot_at(px, py);
					if (id == 16'd0)
						push(elt_pkg::ST_NULL, 16'd0, 16'd0, 16'd0, 1'b1);
					else if (p >= 0 && tbl_id[p] != id)
						push(elt_pkg::ST_OCCUPIED, tbl_id[p], px, py, 1'b1);
					else if (e >= 0) begin
						tbl_x[e] = px;
						tbl_y[e] = py;
						push(elt_pkg::ST_OK, id, px, py, 1'b1);
					end else if (tbl_count >= DEPTH)
						push(elt_pkg::ST_FULL, id, px, py, 1'b1);
					else begin
						tbl_id[tbl_count] = id;
						tbl_x[tbl_count] = px;
						tbl_y[tbl_count] = py;
						tbl_count++;
						push(elt_pkg::ST_OK, id, px, py, 1'b1);
					end
				end
				elt_pkg::ACT_REMOVE: begin
					e = slot_of_entity(id);
					if (id == 16'd0)
						push(elt_pkg::ST_NULL, 16'd0, 16'd0, 16'd0, 1'b1);
					else if (e < 0)
						push(elt_pkg::ST_NOTFOUND, id, 16'd0, 16'd0, 1'b1);
					else begin
						push(elt_pkg::ST_OK, id, tbl_x[e], tbl_y[e], 1'b1);
						for (int i = e; i + 1 < tbl_count; i++) begin
							tbl_id[i] = tbl_id[i+1];
							tbl_x[i] = tbl_x[i+1];
							tbl_y[i] = tbl_y[i+1];
						end
						tbl_count--;
					end
				end
				elt_pkg::ACT_LOCATE: begin
					e = slot_of_entity(id);
					if (id == 16'd0)
						push(elt_pkg::ST_NULL, 16'd0, 16'd0, 16'd0, 1'b1);
					else if (e < 0)
						push(elt_pkg::ST_NOTFOUND, id, 16'd0, 16'd0, 1'b1);
					else
						push(elt_pkg::ST_OK, id, tbl_x[e], tbl_y[e], 1'b1);
				end
				elt_pkg::ACT_VIEW: begin
					hits = 0;
					for (int i = 0; i < tbl_count; i++)
						if (in_rect(i, px, py, cx, cy))
							hits++;
					k = 0;
					for (int i = 0; i < tbl_count; i++)
						if (in_rect(i, px, py, cx, cy)) begin
							k++;
							push(elt_pkg::ST_OK, tbl_id[i], tbl_x[i], tbl_y[i], k == hits);
						end
					if (hits == 0)
						push(elt_pkg::ST_NOTFOUND, 16'd0, 16'd0, 16'd0, 1'b1);
				end
				elt_pkg::ACT_CLEAR: begin
					tbl_count = 0;
					push(elt_pkg::ST_OK, 16'd0, 16'd0, 16'd0, 1'b1);
				end
				default: ;
			endcase
		endfunction

		function void check_result(result_word_t got);
			result_word_t want;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: status %0d id %h x %h y %h last %b",
						got.status, got.id, got.x, got.y, got.last);
				return;
			end
			want = pending_results.pop_front();
			if (got.status != want.status || got.id != want.id || got.x != want.x ||
				got.y != want.y || got.last != want.last) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("word differs: expected status %0d id %h x %h y %h last %b",
						want.status, want.id, want.x, want.y, want.last);
					$display("  got status %0d id %h x %h y %h last %b",
						got.status, got.id, got.x, got.y, got.last);
				end
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b1;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [79:0] s_axis_tdata = '0;
	logic [2:0]  s_axis_tuser = elt_pkg::ACT_FIND;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;
	logic        m_axis_tlast;

	location_scoreboard sb;
	int  sent = 0;
	bit  calm = 1'b0;

	entity_location_table_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always #5 clk = ~clk;

	function int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function logic [15:0] pick_coord();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 16'($signed($urandom_range(0, 8)) - 4);
		if (r < 75)
			case ($urandom_range(0, 3))
				0: return 16'h8000;
				1: return 16'h7fff;
				2: return 16'h8001;
				default: return 16'h7ffe;
			endcase
		return 16'($urandom);
	endfunction

	function logic [15:0] pick_entity();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return 16'd0;
		if (r < 80)
			return 16'($urandom_range(1, 40));
		if (r < 90)
			return ($urandom_range(0, 1) != 0) ? 16'hffff : 16'd1;
		return 16'($urandom);
	endfunction

	task automatic send_request(logic [2:0] action, logic [15:0] id, logic [15:0] px,
		logic [15:0] py, logic [15:0] cx, logic [15:0] cy);
		int gap;
		gap = idle_gap();
		repeat (gap) begin
			@(negedge clk);
			s_axis_tvalid = 1'b0;
			s_axis_tdata = 80'($urandom);
		end
		@(negedge clk);
		s_axis_tvalid = 1'b1;
		s_axis_tuser = action;
		s_axis_tdata = {cy, cx, py, px, id};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sb.note_request(action, id, px, py, cx, cy);
		sent++;
	endtask

	task automatic random_request();
		logic [2:0]  action;
		logic [15:0] px;
		logic [15:0] py;
		logic [15:0] cx;
		logic [15:0] cy;
		int          r;
		r = $urandom_range(0, 99);
		if (r < 40)
			action = elt_pkg::ACT_MOVE;
		else if (r < 52)
			action = elt_pkg::ACT_FIND;
		else if (r < 64)
			action = elt_pkg::ACT_REMOVE;
		else if (r < 76)
			action = elt_pkg::ACT_LOCATE;
		else if (r < 93)
			action = elt_pkg::ACT_VIEW;
		else if (r < 95)
			action = elt_pkg::ACT_CLEAR;
		else
			action = ($urandom_range(0, 1) != 0) ? ACT_SPARE_HI : ACT_SPARE_LO;
		px = pick_coord();
		py = pick_coord();
		cx = 16'($urandom);
		cy = 16'($urandom);
		if (action == elt_pkg::ACT_VIEW) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				px = 16'($signed($urandom_range(0, 8)) - 5);
				py = 16'($signed($urandom_range(0, 8)) - 5);
				cx = px + 16'($urandom_range(0, 6));
				cy = py + 16'($urandom_range(0, 6));
			end else if (r < 85) begin
				px = 16'h8000;
				py = 16'h8000;
				cx = 16'h7fff;
				cy = 16'h7fff;
			end
		end
		send_request(action, pick_entity(), px, py, cx, cy);
	endtask

	// ordered fill up to and past capacity, then listing and compaction
	task automatic fill_table();
		logic [15:0] base;
		base = 16'($urandom_range(100, 60000));
		send_request(elt_pkg::ACT_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom), 16'($urandom));
		for (int k = 0; k <= DEPTH; k++)
			send_request(elt_pkg::ACT_MOVE, base + 16'(k), 16'(k * 3 - 40), pick_coord(),
				16'($urandom), 16'($urandom));
		send_request(elt_pkg::ACT_VIEW, 16'($urandom), 16'h8000, 16'h8000, 16'h7fff,
			16'h7fff);
		send_request(elt_pkg::ACT_REMOVE, base + 16'($urandom_range(0, DEPTH - 1)),
			16'd0, 16'd0, 16'd0, 16'd0);
		send_request(elt_pkg::ACT_MOVE, base + 16'(DEPTH), 16'd77, 16'd77, 16'd0, 16'd0);
		send_request(elt_pkg::ACT_MOVE, base + 16'd1, 16'd77, 16'd77, 16'd0, 16'd0);
		send_request(elt_pkg::ACT_VIEW, 16'd0, 16'hffd0, 16'h8000, 16'h0000, 16'h7fff);
	endtask

	initial begin
		m_axis_tready = 1'b0;
		forever begin
			int gap;
			gap = idle_gap();
			repeat (gap) begin
				@(negedge clk);
				m_axis_tready = 1'b0;
			end
			@(negedge clk);
			m_axis_tready = 1'b1;
			repeat ($urandom_range(0, 6))
				@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result({m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[31:16],
				m_axis_tdata[47:32], m_axis_tlast});
	end

	initial begin
		#20_000_000;
		$display("entity_location_table_unit: mismatch");
		$finish;
	end

	initial begin
		sb = new;
		#1 arst_n = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		send_request(elt_pkg::ACT_CLEAR, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		send_request(elt_pkg::ACT_FIND, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		send_request(elt_pkg::ACT_VIEW, 16'd0, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
		send_request(elt_pkg::ACT_MOVE, 16'd0, 16'd3, 16'd3, 16'd0, 16'd0);
		send_request(elt_pkg::ACT_REMOVE, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		send_request(elt_pkg::ACT_LOCATE, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		send_request(elt_pkg::ACT_LOCATE, 16'd77, 16'd0, 16'd0, 16'd0, 16'd0);
		send_request(elt_pkg::ACT_REMOVE, 16'd77, 16'd0, 16'd0, 16'd0, 16'd0);
		send_request(elt_pkg::ACT_MOVE, 16'd1, 16'h8000, 16'h8000, 16'hffff, 16'hffff);
		send_request(elt_pkg::ACT_MOVE, 16'hffff, 16'h7fff, 16'h7fff, 16'd0, 16'd0);
		send_request(elt_pkg::ACT_MOVE, 16'd2, 16'h7fff, 16'h7fff, 16'd0, 16'd0);
		send_request(elt_pkg::ACT_MOVE, 16'd1, 16'h8000, 16'h8000, 16'd0, 16'd0);
		send_request(elt_pkg::ACT_MOVE, 16'd1, 16'd5, 16'hfffb, 16'd0, 16'd0);
		send_request(elt_pkg::ACT_FIND, 16'd0, 16'h7fff, 16'h7fff, 16'd0, 16'd0);
		send_request(elt_pkg::ACT_FIND, 16'd0, 16'd5, 16'hfffb, 16'd0, 16'd0);
		send_request(elt_pkg::ACT_LOCATE, 16'hffff, 16'd0, 16'd0, 16'd0, 16'd0);
		send_request(ACT_SPARE_LO, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
		send_request(elt_pkg::ACT_VIEW, 16'd0, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
		send_request(elt_pkg::ACT_VIEW, 16'd0, 16'd6, 16'h8000, 16'd4, 16'h7fff);
		send_request(elt_pkg::ACT_VIEW, 16'd0, 16'd5, 16'hfffb, 16'd5, 16'hfffb);
		send_request(ACT_SPARE_HI, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		send_request(elt_pkg::ACT_MOVE, 16'd3, 16'd0, 16'd0, 16'd0, 16'd0);
		send_request(elt_pkg::ACT_REMOVE, 16'hffff, 16'd0, 16'd0, 16'd0, 16'd0);
		send_request(elt_pkg::ACT_VIEW, 16'd0, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
		send_request(elt_pkg::ACT_CLEAR, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);

		sent = 0;
		while (sent < NUM_REQUESTS) begin
			calm = sent >= 180 && sent < 260;
			if (sent == 100 || sent == 330)
				fill_table();
			else
				random_request();
		end
		@(negedge clk);
		s_axis_tvalid = 1'b0;

		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_results.size() == 0)
			$display("entity_location_table_unit: match");
		else
			$display("entity_location_table_unit: mismatch");
		$finish;
	end

endmodule

@@ sim.f @@
sv/elt_pkg.sv
sv/elt_cell.sv
sv/entity_location_table_unit.sv
sv/elt_checker.sv
dv/entity_location_table_unit_test.sv
